### rtl/mfs_pkg.sv
// types and constants of the min-max feature scaler
`timescale 1ns / 1ps
package mfs_pkg;

  localparam int VW = 32;
  localparam int IW = 10;
  localparam int NDIV = 34;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SCALE = 1'b1;

  localparam logic [1:0] REG_SCALING_ON  = 2'd0;
  localparam logic [1:0] REG_TOP_INDEX   = 2'd1;
  localparam logic [1:0] REG_LOWER_BOUND = 2'd2;
  localparam logic [1:0] REG_UPPER_BOUND = 2'd3;

  localparam logic [NDIV-1:0] Q_LIMIT = NDIV'(1) << (VW + 1);

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_MAX  = 2'd2,
    KIND_LIN  = 2'd3
  } kind_t;

  typedef struct packed {
    logic                 action;
    logic [IW-1:0]        feature_index;
    logic signed [VW-1:0] sample_value;
    logic signed [VW-1:0] entry_min;
    logic signed [VW-1:0] entry_max;
  } in_item_t;

  typedef struct packed {
    logic [IW-1:0]        out_index;
    logic signed [VW-1:0] scaled_value;
    logic                 passed_through;
    logic                 saturated;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [IW-1:0]        idx;
    logic signed [VW-1:0] x;
    kind_t                kind;
    logic                 neg;
  } side_t;

  typedef struct packed {
    side_t           sd;
    logic [VW-1:0]   rem;
    logic [NDIV-1:0] q;
    logic [NDIV-1:0] plo;
    logic [VW:0]     d;
    logic            ovf;
  } div_t;

  function automatic logic [VW:0] mag(input logic signed [VW:0] v);
    logic [VW:0] r;
    r = v[VW] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

### rtl/minmax_feature_scaler.sv
// min-max feature scaler: table memory, multiplier and pipelined divider
// pipeline: input and table read, decode, partial products, sum, divider, output
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// loads give no result; an in-range load writes the table at its transfer edge
// reset: registers return to defaults, then a clearing pass zeroes the table
// memory, one entry a cycle, with in_stall high
`timescale 1ns / 1ps
module minmax_feature_scaler
  import mfs_pkg::*;
#(
  parameter int FEATURES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [VW-1:0] cfg_data
);

  localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  logic                 scaling_on_r;
  logic [IW-1:0]        top_index_r;
  logic signed [VW-1:0] lower_r;
  logic signed [VW-1:0] upper_r;

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic adv, accept, in_range;
  logic [AW-1:0] addr;

  logic [2*VW-1:0] mem [FEATURES];
  logic [2*VW-1:0] rd_r;

  side_t s0_r, s1_nxt, s1_r, s2_r, s3_r;
  logic [VW:0] a1_r, b1_r, d1_r, d2_r, d3_r;
  logic [VW:0] a_nxt, b_nxt, d_nxt;
  logic [VW+17:0] pl_r;
  logic [VW+16:0] ph_r;
  logic [2*VW+1:0] p_r;

  div_t dp_r   [NDIV];
  div_t dp_nxt [NDIV];

  out_item_t out_r;
  logic      out_valid_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scaling_on_r <= 1'b1;
      top_index_r  <= '0;
      lower_r      <= -VW'(65536);
      upper_r      <= VW'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALING_ON:  scaling_on_r <= cfg_data[0];
        REG_TOP_INDEX:   top_index_r  <= cfg_data[IW-1:0];
        REG_LOWER_BOUND: lower_r      <= cfg_data;
        REG_UPPER_BOUND: upper_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(FEATURES - 1)) clr_busy_r <= 1'b0;
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = clr_busy_r || !adv;
  assign accept   = in_valid && !in_stall;
  assign addr     = AW'(in_data.feature_index);
  assign in_range = {7'b0, in_data.feature_index} < 17'(FEATURES);

  // table memory
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (accept && in_data.action == ACT_LOAD && in_range) begin
      mem[addr] <= {in_data.entry_min, in_data.entry_max};
    end
    if (adv) rd_r <= mem[addr];
  end

  // decode of the table entry
  always_comb begin
    logic signed [VW-1:0] mn, mx;
    logic signed [VW:0] span, off, den;
    mn = rd_r[2*VW-1:VW];
    mx = rd_r[VW-1:0];
    span = {upper_r[VW-1], upper_r} - {lower_r[VW-1], lower_r};
    off  = {s0_r.x[VW-1], s0_r.x} - {mn[VW-1], mn};
    den  = {mx[VW-1], mx} - {mn[VW-1], mn};
    s1_nxt = s0_r;
    s1_nxt.neg = span[VW] ^ off[VW] ^ den[VW];
    if (s0_r.kind == KIND_PASS || mn == mx) s1_nxt.kind = KIND_PASS;
    else if (s0_r.x == mn)                  s1_nxt.kind = KIND_MIN;
    else if (s0_r.x == mx)                  s1_nxt.kind = KIND_MAX;
    else                                    s1_nxt.kind = KIND_LIN;
    a_nxt = mag(span);
    b_nxt = mag(off);
    d_nxt = mag(den);
  end

  // divider stages, one quotient bit each
  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      div_t src;
      logic [VW:0] t;
      if (k == 0) begin
        src.sd  = s3_r;
        src.rem = p_r[2*VW+1:NDIV];
        src.q   = '0;
        src.plo = p_r[NDIV-1:0];
        src.d   = d3_r;
        src.ovf = {1'b0, p_r[2*VW+1:NDIV]} >= d3_r;
      end else begin
        src = dp_r[k-1];
      end
      t = {src.rem, src.plo[NDIV-1-k]};
      dp_nxt[k] = src;
      if (t >= src.d) begin
        dp_nxt[k].rem = VW'(t - src.d);
        dp_nxt[k].q   = {src.q[NDIV-2:0], 1'b1};
      end else begin
        dp_nxt[k].rem = t[VW-1:0];
        dp_nxt[k].q   = {src.q[NDIV-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      for (int k = 0; k < NDIV; k++) dp_r[k].sd.valid <= 1'b0;
    end else if (adv) begin
      s0_r.valid <= accept && in_data.action == ACT_SCALE;
      s0_r.idx   <= in_data.feature_index;
      s0_r.x     <= in_data.sample_value;
      s0_r.kind  <= (!scaling_on_r || in_data.feature_index > top_index_r || !in_range)
                    ? KIND_PASS : KIND_LIN;
      s0_r.neg   <= 1'b0;
      s1_r <= s1_nxt;
      a1_r <= a_nxt;
      b1_r <= b_nxt;
      d1_r <= d_nxt;
      s2_r <= s1_r;
      pl_r <= a1_r * b1_r[16:0];
      ph_r <= a1_r * b1_r[VW:17];
      d2_r <= d1_r;
      s3_r <= s2_r;
      p_r  <= (2*VW+2)'(pl_r) + ((2*VW+2)'(ph_r) << 17);
      d3_r <= d2_r;
      for (int k = 0; k < NDIV; k++) dp_r[k] <= dp_nxt[k];
    end
  end

  // final add, result select, saturation and output register
  always_ff @(posedge clk) begin
    div_t l;
    logic [NDIV-1:0] qc;
    logic signed [VW+3:0] sum;
    logic signed [VW-1:0] val;
    logic pass, sat;
    l   = dp_r[NDIV-1];
    qc  = (l.ovf || l.q > Q_LIMIT) ? Q_LIMIT : l.q;
    sum = {{4{lower_r[VW-1]}}, lower_r}
          + (l.sd.neg ? -(VW+4)'({2'b0, qc}) : (VW+4)'({2'b0, qc}));
    pass = 1'b0;
    sat  = 1'b0;
    case (l.sd.kind)
      KIND_PASS: begin
        val  = l.sd.x;
        pass = 1'b1;
      end
      KIND_MIN: val = lower_r;
      KIND_MAX: val = upper_r;
      default: begin
        if (!sum[VW+3] && sum[VW+2:VW-1] != '0) begin
          val = {1'b0, {(VW-1){1'b1}}};
          sat = 1'b1;
        end else if (sum[VW+3] && sum[VW+2:VW-1] != '1) begin
          val = {1'b1, {(VW-1){1'b0}}};
          sat = 1'b1;
        end else begin
          val = sum[VW-1:0];
        end
      end
    endcase
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= l.sd.valid;
      out_r.out_index      <= l.sd.idx;
      out_r.scaled_value   <= val;
      out_r.passed_through <= pass;
      out_r.saturated      <= sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/mfs_checker.sv
// port checker for the min-max feature scaler, bound to the top level
`timescale 1ns / 1ps
module mfs_checker
  import mfs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> in_stall)
    else $error("input taken before table clear");

  // a stalled result blocks new transfers
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

  // pass and saturation exclude each other
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.passed_through && out_data.saturated))
    else $error("pass and saturated both set");

endmodule

bind minmax_feature_scaler mfs_checker u_mfs_checker (.*);
